[src/bie_pkg.sv]
// ----------------------------------------------------------------------------
// bie_pkg
// Shared types, constants and helper functions of the 2x2 block encoder.
// ----------------------------------------------------------------------------
package bie_pkg;

    typedef logic signed [17:0] t_q;

    typedef struct packed {
        t_q y;
        t_q pb;
        t_q pr;
    } t_lane_out;

    localparam int DIV_LAT   = 17;
    localparam int LANE_LAT  = DIV_LAT + 2;
    localparam int MERGE_LAT = 4;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam int LUMA_SCALE     = 511;
    localparam int GRADIENT_SCALE = 50;
    localparam int GRAD_LIMIT     = 19660;

    localparam t_q Q_MAX = 18'sd131071;
    localparam t_q Q_MIN = -18'sd131072;

    localparam logic [7:0] CFG_PIXEL_MAX  = 8'd0;
    localparam logic [7:0] CFG_TABLE_LOW  = 8'd1;
    localparam logic [7:0] CFG_TABLE_HIGH = 8'd2;

    localparam logic [15:0] PIXEL_MAX_RESET = 16'd255;

    // color matrix in Q0.16
    localparam t_q K_YR  = 18'sd19595;
    localparam t_q K_YG  = 18'sd38470;
    localparam t_q K_YB  = 18'sd7471;
    localparam t_q K_PBR = -18'sd11058;
    localparam t_q K_PBG = -18'sd21710;
    localparam t_q K_PBB = 18'sd32768;
    localparam t_q K_PRR = 18'sd32768;
    localparam t_q K_PRG = -18'sd27439;
    localparam t_q K_PRB = -18'sd5329;

    function automatic t_q sat_q(input logic signed [21:0] v);
        t_q r;
        if (v > 22'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 22'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    function automatic logic [4:0] grad_code(input t_q v);
        logic [17:0] m;
        logic [23:0] p;
        logic [7:0]  q;
        logic [4:0]  r;
        m = v[17] ? 18'(-v) : 18'(v);
        p = 24'(m) * 24'(GRADIENT_SCALE) + 24'd32768;
        q = p[23:16];
        if (q > 8'd15) begin
            q = 8'd15;
        end
        r = q[4:0];
        if (v[17]) begin
            r = 5'(-r);
        end
        if (v > 18'(GRAD_LIMIT)) begin
            r = 5'd15;
        end else if (v < -18'(GRAD_LIMIT)) begin
            r = 5'(-15);
        end
        return r;
    endfunction

endpackage

[src/bie_div.sv]
// ----------------------------------------------------------------------------
// bie_div
// Pipelined restoring divider: floor(x * 65536 / d), one quotient bit a stage,
// saturated to 131071.
// ----------------------------------------------------------------------------
module bie_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_x,
    input  logic [15:0] i_d,
    output logic [16:0] o_n
);
    import bie_pkg::*;

    logic [15:0] r_rem [DIV_LAT];
    logic [16:0] r_q   [DIV_LAT];
    logic        r_sat [DIV_LAT];
    logic [15:0] dd;

    assign dd = (i_d == 16'd0) ? 16'd1 : i_d;

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
        logic [16:0] t;
        logic [16:0] qin;
        logic        satin;
        logic        ge;
        if (k == 0) begin : g_first
            assign t     = {1'b0, i_x};
            assign qin   = '0;
            // quotient would not fit 17 bits
            assign satin = {1'b0, i_x} >= {dd, 1'b0};
        end else begin : g_next
            assign t     = {r_rem[k-1], 1'b0};
            assign qin   = r_q[k-1];
            assign satin = r_sat[k-1];
        end
        assign ge = t >= {1'b0, dd};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? 16'(t - {1'b0, dd}) : t[15:0];
                r_q[k]   <= qin | (17'(ge) << (DIV_LAT - 1 - k));
                r_sat[k] <= satin;
            end
        end
    end

    assign o_n = r_sat[DIV_LAT-1] ? 17'h1FFFF : r_q[DIV_LAT-1];

endmodule

[src/bie_lane.sv]
// ----------------------------------------------------------------------------
// bie_lane
// One pixel: normalize three components and convert to Y, Pb, Pr.
// ----------------------------------------------------------------------------
module bie_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_red,
    input  logic [15:0]        i_green,
    input  logic [15:0]        i_blue,
    input  logic [15:0]        i_pixel_max,
    output bie_pkg::t_lane_out o_pix
);
    import bie_pkg::*;

    logic [16:0] w_nr, w_ng, w_nb;
    t_q          sr, sg, sb;
    logic signed [35:0] r_p [9];
    t_lane_out   r_pix;
    t_lane_out   n_pix;

    bie_div u_div_r (.i_clk(i_clk), .i_en(i_en), .i_x(i_red),   .i_d(i_pixel_max), .o_n(w_nr));
    bie_div u_div_g (.i_clk(i_clk), .i_en(i_en), .i_x(i_green), .i_d(i_pixel_max), .o_n(w_ng));
    bie_div u_div_b (.i_clk(i_clk), .i_en(i_en), .i_x(i_blue),  .i_d(i_pixel_max), .o_n(w_nb));

    assign sr = $signed({1'b0, w_nr});
    assign sg = $signed({1'b0, w_ng});
    assign sb = $signed({1'b0, w_nb});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= sr * K_YR;
            r_p[1] <= sg * K_YG;
            r_p[2] <= sb * K_YB;
            r_p[3] <= sr * K_PBR;
            r_p[4] <= sg * K_PBG;
            r_p[5] <= sb * K_PBB;
            r_p[6] <= sr * K_PRR;
            r_p[7] <= sg * K_PRG;
            r_p[8] <= sb * K_PRB;
        end
    end

    function automatic t_q mix(input logic signed [35:0] a, input logic signed [35:0] b,
                               input logic signed [35:0] c);
        logic signed [37:0] s;
        s = 38'(a) + 38'(b) + 38'(c) + 38'sd32768;
        return sat_q(s[37:16]);
    endfunction

    always_comb begin
        n_pix.y  = mix(r_p[0], r_p[1], r_p[2]);
        n_pix.pb = mix(r_p[3], r_p[4], r_p[5]);
        n_pix.pr = mix(r_p[6], r_p[7], r_p[8]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

[src/bie_merge.sv]
// ----------------------------------------------------------------------------
// bie_merge
// Combine the four lanes: Haar transform, quantize, nearest chroma level, pack.
// ----------------------------------------------------------------------------
module bie_merge (
    input  logic               i_clk,
    input  logic               i_en,
    input  bie_pkg::t_lane_out i_pix [4],
    input  logic [63:0]        i_table_low,
    input  logic [63:0]        i_table_high,
    output logic [31:0]        o_code
);
    import bie_pkg::*;

    // stage 1
    t_q r_a, r_b, r_c, r_d, r_pb, r_pr;
    // stage 2
    logic [8:0]  r_la, r_la3;
    logic [4:0]  r_gb, r_gc, r_gd, r_gb3, r_gc3, r_gd3;
    logic [18:0] r_dpb [16];
    logic [18:0] r_dpr [16];
    // stage 3
    logic [18:0] r_mpb_d [4];
    logic [3:0]  r_mpb_i [4];
    logic [18:0] r_mpr_d [4];
    logic [3:0]  r_mpr_i [4];
    // stage 4
    logic [31:0] r_code;

    function automatic t_q avg4(input t_q p, input t_q q, input t_q s, input t_q t,
                                input logic [1:0] neg);
        logic signed [21:0] sum;
        logic signed [21:0] w;
        w   = 22'(q);
        sum = 22'(p) + (neg[0] ? -w : w);
        w   = 22'(s);
        sum = sum + (neg[1] ? -w : w);
        sum = sum + 22'(t) + 22'sd2;
        return sat_q(22'(sum >>> 2));
    endfunction

    // stage 1: transform with y1 = tl, y2 = tr, y3 = bl, y4 = br
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= avg4(i_pix[3].y, i_pix[2].y, i_pix[1].y, i_pix[0].y, 2'b00);
            r_b  <= avg4(i_pix[3].y, i_pix[2].y, i_pix[1].y, -i_pix[0].y, 2'b10);
            r_c  <= avg4(i_pix[3].y, i_pix[2].y, i_pix[1].y, -i_pix[0].y, 2'b01);
            r_d  <= avg4(i_pix[3].y, i_pix[2].y, i_pix[1].y, i_pix[0].y, 2'b11);
            r_pb <= avg4(i_pix[0].pb, i_pix[1].pb, i_pix[2].pb, i_pix[3].pb, 2'b00);
            r_pr <= avg4(i_pix[0].pr, i_pix[1].pr, i_pix[2].pr, i_pix[3].pr, 2'b00);
        end
    end

    // stage 2
    logic signed [28:0] la_p;
    logic signed [12:0] la_r;
    logic [8:0]         n_la;

    always_comb begin
        la_p = 29'(r_a) * 29'(LUMA_SCALE) + 29'sd32768;
        la_r = la_p[28:16];
        if (la_r < 13'sd0) begin
            n_la = 9'd0;
        end else if (la_r > 13'sd511) begin
            n_la = 9'd511;
        end else begin
            n_la = la_r[8:0];
        end
    end

    function automatic logic [18:0] level_gap(input t_q v, input logic [7:0] lvl);
        logic signed [19:0] df;
        df = 20'(v) - $signed({{4{lvl[7]}}, lvl, 8'h00});
        return df[19] ? 19'(-df) : df[18:0];
    endfunction

    for (genvar e = 0; e < 16; e++) begin : g_dist
        logic [7:0] lvl;
        if (e < 8) begin : g_lo
            assign lvl = i_table_low[e*8 +: 8];
        end else begin : g_hi
            assign lvl = i_table_high[(e-8)*8 +: 8];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dpb[e] <= level_gap(r_pb, lvl);
                r_dpr[e] <= level_gap(r_pr, lvl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la <= n_la;
            r_gb <= grad_code(r_b);
            r_gc <= grad_code(r_c);
            r_gd <= grad_code(r_d);
        end
    end

    // stage 3: pick within groups of four, lower index wins a tie
    function automatic logic [22:0] pick(input logic [18:0] da, input logic [3:0] ia,
                                         input logic [18:0] db, input logic [3:0] ib);
        return (db < da) ? {db, ib} : {da, ia};
    endfunction

    for (genvar g = 0; g < 4; g++) begin : g_grp
        logic [22:0] pb0, pb1, pbm, pr0, pr1, prm;
        assign pb0 = pick(r_dpb[4*g], 4'(4*g), r_dpb[4*g+1], 4'(4*g+1));
        assign pb1 = pick(r_dpb[4*g+2], 4'(4*g+2), r_dpb[4*g+3], 4'(4*g+3));
        assign pbm = pick(pb0[22:4], pb0[3:0], pb1[22:4], pb1[3:0]);
        assign pr0 = pick(r_dpr[4*g], 4'(4*g), r_dpr[4*g+1], 4'(4*g+1));
        assign pr1 = pick(r_dpr[4*g+2], 4'(4*g+2), r_dpr[4*g+3], 4'(4*g+3));
        assign prm = pick(pr0[22:4], pr0[3:0], pr1[22:4], pr1[3:0]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mpb_d[g] <= pbm[22:4];
                r_mpb_i[g] <= pbm[3:0];
                r_mpr_d[g] <= prm[22:4];
                r_mpr_i[g] <= prm[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_la3 <= r_la;
            r_gb3 <= r_gb;
            r_gc3 <= r_gc;
            r_gd3 <= r_gd;
        end
    end

    // stage 4: final pick and pack
    logic [22:0] fb0, fb1, fbm, fr0, fr1, frm;
    assign fb0 = pick(r_mpb_d[0], r_mpb_i[0], r_mpb_d[1], r_mpb_i[1]);
    assign fb1 = pick(r_mpb_d[2], r_mpb_i[2], r_mpb_d[3], r_mpb_i[3]);
    assign fbm = pick(fb0[22:4], fb0[3:0], fb1[22:4], fb1[3:0]);
    assign fr0 = pick(r_mpr_d[0], r_mpr_i[0], r_mpr_d[1], r_mpr_i[1]);
    assign fr1 = pick(r_mpr_d[2], r_mpr_i[2], r_mpr_d[3], r_mpr_i[3]);
    assign frm = pick(fr0[22:4], fr0[3:0], fr1[22:4], fr1[3:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_code <= {r_la3, r_gb3, r_gc3, r_gd3, fbm[3:0], frm[3:0]};
        end
    end

    assign o_code = r_code;

endmodule

[src/block_image_encoder_top.sv]
// ----------------------------------------------------------------------------
// block_image_encoder_top
// 2x2 RGB block to 32-bit Y/Pb/Pr Haar code word, four pixel lanes and a merge.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   in        to block   i_in_valid / o_in_stall    twelve 16-bit components
//   out       from block o_out_valid / i_out_stall  o_code_word[31:0]
//   cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while the result is not stalled; 17 divider steps per component,
// 2 color-mix stages, 4 merge stages ending in the output register.
// A stalled result freezes the whole pipeline; input stall follows it.
// Synchronous active-low reset clears valid bits and level tables, sets pixel max to 255.
// ----------------------------------------------------------------------------
module block_image_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_tl_red,
    input  logic [15:0] i_tl_green,
    input  logic [15:0] i_tl_blue,
    input  logic [15:0] i_tr_red,
    input  logic [15:0] i_tr_green,
    input  logic [15:0] i_tr_blue,
    input  logic [15:0] i_bl_red,
    input  logic [15:0] i_bl_green,
    input  logic [15:0] i_bl_blue,
    input  logic [15:0] i_br_red,
    input  logic [15:0] i_br_green,
    input  logic [15:0] i_br_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_code_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import bie_pkg::*;

    logic [15:0]          r_pixel_max;
    logic [63:0]          r_table_low;
    logic [63:0]          r_table_high;
    logic [TOTAL_LAT-1:0] r_vld;
    logic                 en;
    t_lane_out            w_pix [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_max  <= PIXEL_MAX_RESET;
            r_table_low  <= '0;
            r_table_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PIXEL_MAX) begin
                r_pixel_max <= i_cfg_data[15:0];
            end else if (i_cfg_index == CFG_TABLE_LOW) begin
                r_table_low <= i_cfg_data;
            end else if (i_cfg_index == CFG_TABLE_HIGH) begin
                r_table_high <= i_cfg_data;
            end
        end
    end

    // advance unless the finished item is held
    assign en         = !(r_vld[TOTAL_LAT-1] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_in_valid};
        end
    end

    bie_lane u_lane_tl (.i_clk(i_clk), .i_en(en), .i_red(i_tl_red), .i_green(i_tl_green),
                        .i_blue(i_tl_blue), .i_pixel_max(r_pixel_max), .o_pix(w_pix[0]));
    bie_lane u_lane_tr (.i_clk(i_clk), .i_en(en), .i_red(i_tr_red), .i_green(i_tr_green),
                        .i_blue(i_tr_blue), .i_pixel_max(r_pixel_max), .o_pix(w_pix[1]));
    bie_lane u_lane_bl (.i_clk(i_clk), .i_en(en), .i_red(i_bl_red), .i_green(i_bl_green),
                        .i_blue(i_bl_blue), .i_pixel_max(r_pixel_max), .o_pix(w_pix[2]));
    bie_lane u_lane_br (.i_clk(i_clk), .i_en(en), .i_red(i_br_red), .i_green(i_br_green),
                        .i_blue(i_br_blue), .i_pixel_max(r_pixel_max), .o_pix(w_pix[3]));

    bie_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_pix       (w_pix),
        .i_table_low (r_table_low),
        .i_table_high(r_table_high),
        .o_code      (o_code_word)
    );

    assign o_out_valid = r_vld[TOTAL_LAT-1];

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives 2x2 RGB pixel blocks into the encoder under random idling and stalls,
// predicts each packed code word in fixed point and checks it in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bie_pkg::*;

    typedef logic [15:0] t_block [12];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] pix [12];
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_code_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    logic [15:0] pixel_max_q;
    logic [63:0] table_low_q;
    logic [63:0] table_high_q;

    logic [31:0] code_queue [$];
    int          error_count = 0;
    bit          quiet = 1'b0;
    bit          send_idle = 1'b1;
    int          hold_cycles = 0;
    int          hold_request = 0;

    initial begin
        for (int k = 0; k < 12; k++) begin
            pix[k] = '0;
        end
    end

    block_image_encoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_tl_red   (pix[0]),
        .i_tl_green (pix[1]),
        .i_tl_blue  (pix[2]),
        .i_tr_red   (pix[3]),
        .i_tr_green (pix[4]),
        .i_tr_blue  (pix[5]),
        .i_bl_red   (pix[6]),
        .i_bl_green (pix[7]),
        .i_bl_blue  (pix[8]),
        .i_br_red   (pix[9]),
        .i_br_green (pix[10]),
        .i_br_blue  (pix[11]),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_code_word(o_code_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint round_shift(longint v, int s);
        longint t;
        t = v + (longint'(1) <<< (s - 1));
        if (t >= 0) begin
            return t >>> s;
        end
        return -((-t + ((longint'(1) <<< s) - 1)) >>> s);
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > 131071) begin
            return 131071;
        end
        if (v < -131072) begin
            return -131072;
        end
        return v;
    endfunction

    function automatic longint norm_component(logic [15:0] x);
        longint dv;
        longint q;
        dv = (pixel_max_q == 0) ? 1 : longint'(pixel_max_q);
        q = (longint'(x) << 16) / dv;
        return (q > 131071) ? 131071 : q;
    endfunction

    function automatic longint color_mix(longint r, longint g, longint b,
                                         longint kr, longint kg, longint kb);
        return clamp_q(round_shift(kr * r + kg * g + kb * b, 16));
    endfunction

    function automatic logic [4:0] gradient_field(longint v);
        longint m;
        longint q;
        if (v > 19660) begin
            return 5'd15;
        end
        if (v < -19660) begin
            return 5'(-15);
        end
        m = (v < 0) ? -v : v;
        q = (m * 50 + 32768) >>> 16;
        if (q > 15) begin
            q = 15;
        end
        if (v < 0) begin
            q = -q;
        end
        return 5'(q);
    endfunction

    function automatic logic [3:0] nearest_level(longint v);
        logic [3:0]  best;
        longint      best_gap;
        logic [7:0]  lvl_byte;
        longint      level_gap;
        best = '0;
        best_gap = 64'sh7fffffffffffffff;
        for (int e = 0; e < 16; e++) begin
            lvl_byte = (e < 8) ? table_low_q[(e % 8) * 8 +: 8]
                               : table_high_q[(e % 8) * 8 +: 8];
            level_gap = v - longint'($signed(lvl_byte)) * 256;
            if (level_gap < 0) begin
                level_gap = -level_gap;
            end
            // strict compare keeps the lowest index on a tie
            if (level_gap < best_gap) begin
                best_gap = level_gap;
                best = 4'(e);
            end
        end
        return best;
    endfunction

    function automatic logic [31:0] predict_code(t_block blk);
        longint y [4];
        longint pb_sum;
        longint pr_sum;
        longint r, g, b, av, bv, cv, dv, la;
        pb_sum = 0;
        pr_sum = 0;
        for (int p = 0; p < 4; p++) begin
            r = norm_component(blk[p * 3]);
            g = norm_component(blk[p * 3 + 1]);
            b = norm_component(blk[p * 3 + 2]);
            y[p] = color_mix(r, g, b, 19595, 38470, 7471);
            pb_sum += color_mix(r, g, b, -11058, -21710, 32768);
            pr_sum += color_mix(r, g, b, 32768, -27439, -5329);
        end
        av = clamp_q(round_shift(y[0] + y[1] + y[2] + y[3], 2));
        bv = clamp_q(round_shift(y[3] + y[2] - y[1] - y[0], 2));
        cv = clamp_q(round_shift(y[3] - y[2] + y[1] - y[0], 2));
        dv = clamp_q(round_shift(y[3] - y[2] - y[1] + y[0], 2));
        la = round_shift(av * 511, 16);
        la = (la < 0) ? 0 : ((la > 511) ? 511 : la);
        return {9'(la), gradient_field(bv), gradient_field(cv), gradient_field(dv),
                nearest_level(clamp_q(round_shift(pb_sum, 2))),
                nearest_level(clamp_q(round_shift(pr_sum, 2)))};
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (code_queue.size() == 0) begin
                report_mismatch("unexpected code word", o_code_word, 'x);
            end else begin
                want = code_queue.pop_front();
                if (o_code_word !== want) begin
                    report_mismatch("code word", o_code_word, want);
                end
            end
        end
    end

    // receiver stall: random bursts, a long hold on request, none when quiet
    always @(posedge i_clk) begin
        int burst;
        if (hold_request > 0) begin
            hold_cycles <= hold_request - 1;
            i_out_stall <= 1'b1;
            hold_request = 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 11);
            hold_cycles <= burst - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_block(t_block blk);
        int gap;
        i_cfg_valid <= 1'b0;
        if (send_idle && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int k = 0; k < 12; k++) begin
            pix[k] <= blk[k];
        end
        i_in_valid <= 1'b1;
        code_queue.push_back(predict_code(blk));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (code_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_PIXEL_MAX) begin
            pixel_max_q = value[15:0];
        end else if (idx == CFG_TABLE_LOW) begin
            table_low_q = value;
        end else if (idx == CFG_TABLE_HIGH) begin
            table_high_q = value;
        end
    endtask

    function automatic t_block fill_block(logic [15:0] v);
        t_block blk;
        for (int k = 0; k < 12; k++) begin
            blk[k] = v;
        end
        return blk;
    endfunction

    function automatic t_block random_block(int hi);
        t_block blk;
        for (int k = 0; k < 12; k++) begin
            blk[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, hi));
        end
        return blk;
    endfunction

    task automatic test_directed();
        t_block blk;
        send_block(fill_block(16'd0));
        send_block(fill_block(16'd255));
        send_block(fill_block(16'hffff));
        // strong gradients in each direction
        blk = fill_block(16'd0);
        blk[9] = 255; blk[10] = 255; blk[11] = 255;
        send_block(blk);
        blk = fill_block(16'd255);
        blk[9] = 0; blk[10] = 0; blk[11] = 0;
        send_block(blk);
        blk = fill_block(16'd0);
        blk[3] = 255; blk[4] = 255; blk[5] = 255;
        send_block(blk);
        // small gradient, rounded instead of clamped
        blk = fill_block(16'd100);
        blk[10] = 120;
        send_block(blk);
        // pure red and pure blue for chroma extremes
        blk = fill_block(16'd0);
        for (int p = 0; p < 4; p++) blk[p * 3] = 255;
        send_block(blk);
        blk = fill_block(16'd0);
        for (int p = 0; p < 4; p++) blk[p * 3 + 2] = 255;
        send_block(blk);
        blk = fill_block(16'haaaa);
        blk[1] = 16'h5555;
        send_block(blk);
        drain();
    endtask

    task automatic test_config_sweep();
        // zero divisor acts as one; components above it saturate
        write_reg(CFG_PIXEL_MAX, 64'd0);
        write_reg(CFG_TABLE_LOW, 64'h0807_0605_0403_0201);
        write_reg(CFG_TABLE_HIGH, 64'h8000_ff80_7f7f_f0f0);
        send_block(fill_block(16'd0));
        send_block(fill_block(16'd1));
        send_block(random_block(3));
        drain();
        write_reg(CFG_PIXEL_MAX, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_TABLE_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_TABLE_HIGH, 64'd0);
        send_block(fill_block(16'hffff));
        send_block(random_block(65535));
        // unknown index must not disturb the registers
        drain();
        write_reg(8'd3, 64'h1234);
        write_reg(8'hff, 64'h5678);
        send_block(random_block(65535));
        drain();
    endtask

    task automatic test_random(int count, logic [15:0] pmax);
        write_reg(CFG_PIXEL_MAX, {48'd0, pmax});
        write_reg(CFG_TABLE_LOW, {$urandom, $urandom});
        write_reg(CFG_TABLE_HIGH, {$urandom, $urandom});
        for (int n = 0; n < count; n++) begin
            send_block(random_block(pmax));
        end
        drain();
    endtask

    task automatic test_backpressure();
        // receiver holds off long while sender keeps offering
        @(posedge i_clk);
        hold_request = 60;
        send_idle = 1'b0;
        for (int n = 0; n < 60; n++) begin
            send_block(random_block(255));
        end
        send_idle = 1'b1;
        drain();
    endtask

    task automatic test_quiet();
        quiet = 1'b1;
        for (int n = 0; n < 170; n++) begin
            send_block(random_block(1023));
        end
        drain();
    endtask

    initial begin
        pixel_max_q = PIXEL_MAX_RESET;
        table_low_q = '0;
        table_high_q = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random(200, 16'd255);
        test_random(150, 16'd1023);
        test_random(150, 16'hffff);
        test_random(100, 16'd1);
        test_backpressure();
        test_quiet();
        if (error_count == 0 && code_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
